[rtl/core/dnsp_pkg.sv]
`timescale 1ns / 1ps
// Package with the shared constants and types of the DNS A-record response parser.
package dnsp_pkg;

   localparam int MAX_MESSAGE = 512;
   localparam int POS_W       = $clog2(MAX_MESSAGE + 1);

   localparam logic [15:0] EXPECTED_ID_RESET = 16'h1234;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_EXPECTED_ID = 1'b0;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_ID_ERR    = 3'd2;
   localparam logic [2:0] STATUS_NAME_ERR  = 3'd3;
   localparam logic [2:0] STATUS_SERVER    = 3'd4;

   typedef struct packed {
      logic        record_valid;
      logic [31:0] address;
      logic        done_res;
      logic [2:0]  status;
      logic [7:0]  record_count;
   } rsp_word_type;

endpackage

[rtl/core/dnsp_req_if.sv]
`timescale 1ns / 1ps
// Interface of the message byte channel.
interface dnsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

[rtl/core/dnsp_rsp_if.sv]
`timescale 1ns / 1ps
// Interface of the result channel.
interface dnsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_valid;
   logic [31:0] address;
   logic        done_res;
   logic [2:0]  status;
   logic [7:0]  record_count;

   modport source (output valid, output record_valid, output address, output done_res,
                   output status, output record_count, input ready);
   modport sink (input valid, input record_valid, input address, input done_res,
                 input status, input record_count, output ready);
endinterface

[rtl/core/dnsp_csr.sv]
`timescale 1ns / 1ps
// APB register file holding the expected transaction id.
module dnsp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dnsp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dnsp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dnsp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [15:0]                      expected_id
);

   logic [15:0] expected_id_ff;
   logic [15:0] expected_id_in;
   logic        sel_id;

   assign csr_pready = 1'b1;
   assign sel_id     = (csr_paddr[2] == dnsp_pkg::REG_EXPECTED_ID);

   always_comb begin
      expected_id_in = expected_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_id) begin
         expected_id_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= dnsp_pkg::EXPECTED_ID_RESET;
      end else begin
         expected_id_ff <= expected_id_in;
      end
   end

   assign csr_prdata  = sel_id ? {{(dnsp_pkg::CSR_DATA_W-16){1'b0}}, expected_id_ff}
                               : '0;
   assign expected_id = expected_id_ff;

endmodule

[rtl/core/dnsp_parse.sv]
`timescale 1ns / 1ps
// Message parse state and the per-byte next-state and result logic.
module dnsp_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              byte_value,
   input  logic                    last_byte,
   input  logic [15:0]             expected_id,
   output logic                    res_valid,
   output dnsp_pkg::rsp_word_type  res_word
);

   localparam logic [3:0] PH_HEADER = 4'd0;
   localparam logic [3:0] PH_QNAME  = 4'd1;
   localparam logic [3:0] PH_QLABEL = 4'd2;
   localparam logic [3:0] PH_QTAIL  = 4'd3;
   localparam logic [3:0] PH_ANAME  = 4'd4;
   localparam logic [3:0] PH_ALABEL = 4'd5;
   localparam logic [3:0] PH_APTR   = 4'd6;
   localparam logic [3:0] PH_AFIXED = 4'd7;
   localparam logic [3:0] PH_ADATA  = 4'd8;
   localparam logic [3:0] PH_IDLE   = 4'd9;

   localparam logic [15:0] FIXED_LEN  = 16'd10;
   localparam logic [15:0] QTAIL_LEN  = 16'd4;
   localparam logic [15:0] QPTR_LEN   = 16'd5;
   localparam logic [7:0]  PTR_MASK   = 8'hC0;
   localparam logic [3:0]  RCODE_NAME = 4'd3;
   localparam int          HEADER_LEN = 12;

   logic [dnsp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] id_ff, id_in;
   logic [3:0]  code_ff, code_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] seen_ff, seen_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  found_ff, found_in;
   logic [15:0] seen_inc;
   logic [15:0] skip_dec;
   logic        is_ptr;
   logic        rec;
   logic        hit;
   logic [2:0]  status;

   assign seen_inc = seen_ff + 16'd1;
   assign skip_dec = skip_ff - 16'd1;
   assign is_ptr   = ((byte_value & PTR_MASK) == PTR_MASK);
   assign hit      = (rtype_ff == 16'd1) && (dlen_ff == 16'd4);

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      id_in    = id_ff;
      code_in  = code_ff;
      total_in = total_ff;
      seen_in  = seen_ff;
      skip_in  = skip_ff;
      rtype_in = rtype_ff;
      dlen_in  = dlen_ff;
      addr_in  = addr_ff;
      found_in = found_ff;
      rec      = 1'b0;
      if (pos_ff < dnsp_pkg::POS_W'(dnsp_pkg::MAX_MESSAGE)) begin
         pos_in = pos_ff + dnsp_pkg::POS_W'(1);
         case (phase_ff)
            PH_HEADER: begin
               case (pos_ff)
                  dnsp_pkg::POS_W'(0): id_in    = {byte_value, 8'h00};
                  dnsp_pkg::POS_W'(1): id_in    = id_ff | {8'h00, byte_value};
                  dnsp_pkg::POS_W'(3): code_in  = byte_value[3:0];
                  dnsp_pkg::POS_W'(6): total_in = {byte_value, 8'h00};
                  dnsp_pkg::POS_W'(7): total_in = total_ff | {8'h00, byte_value};
                  default: ;
               endcase
               if (pos_ff == dnsp_pkg::POS_W'(HEADER_LEN - 1)) begin
                  phase_in = (id_ff == expected_id && code_ff == 4'd0) ? PH_QNAME : PH_IDLE;
               end
            end
            PH_QNAME: begin
               if (byte_value == 8'd0) begin
                  skip_in  = QTAIL_LEN;
                  phase_in = PH_QTAIL;
               end else if (is_ptr) begin
                  skip_in  = QPTR_LEN;
                  phase_in = PH_QTAIL;
               end else begin
                  skip_in  = {8'h00, byte_value};
                  phase_in = PH_QLABEL;
               end
            end
            PH_QLABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = PH_QNAME;
               end
            end
            PH_QTAIL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = (seen_ff < total_ff) ? PH_ANAME : PH_IDLE;
               end
            end
            PH_ANAME: begin
               if (byte_value == 8'd0) begin
                  skip_in  = FIXED_LEN;
                  phase_in = PH_AFIXED;
               end else if (is_ptr) begin
                  skip_in  = 16'd1;
                  phase_in = PH_APTR;
               end else begin
                  skip_in  = {8'h00, byte_value};
                  phase_in = PH_ALABEL;
               end
            end
            PH_ALABEL: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = PH_ANAME;
               end
            end
            PH_APTR: begin
               skip_in  = FIXED_LEN;
               phase_in = PH_AFIXED;
            end
            PH_AFIXED: begin
               // The remaining count tells which of the ten fixed bytes this is.
               if (skip_ff == FIXED_LEN) begin
                  rtype_in = {byte_value, 8'h00};
               end else if (skip_ff == FIXED_LEN - 16'd1) begin
                  rtype_in = rtype_ff | {8'h00, byte_value};
               end else if (skip_ff == 16'd2) begin
                  dlen_in = {byte_value, 8'h00};
               end else if (skip_ff == 16'd1) begin
                  dlen_in = dlen_ff | {8'h00, byte_value};
               end
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  addr_in = 32'd0;
                  if (dlen_in == 16'd0) begin
                     seen_in  = seen_inc;
                     phase_in = (seen_inc < total_ff) ? PH_ANAME : PH_IDLE;
                  end else begin
                     skip_in  = dlen_in;
                     phase_in = PH_ADATA;
                  end
               end
            end
            PH_ADATA: begin
               addr_in = {addr_ff[23:0], byte_value};
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  if (hit && found_ff != 8'hFF) begin
                     found_in = found_ff + 8'd1;
                  end
                  seen_in  = seen_inc;
                  phase_in = (seen_inc < total_ff) ? PH_ANAME : PH_IDLE;
                  rec      = hit;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pos_in < dnsp_pkg::POS_W'(HEADER_LEN)) begin
         status = dnsp_pkg::STATUS_SHORT;
      end else if (id_in != expected_id) begin
         status = dnsp_pkg::STATUS_ID_ERR;
      end else if (code_in == RCODE_NAME) begin
         status = dnsp_pkg::STATUS_NAME_ERR;
      end else if (code_in != 4'd0) begin
         status = dnsp_pkg::STATUS_SERVER;
      end else begin
         status = dnsp_pkg::STATUS_OK;
      end
   end

   assign res_valid             = rec || last_byte;
   assign res_word.record_valid = rec;
   assign res_word.address      = rec ? addr_in : 32'd0;
   assign res_word.done_res     = last_byte;
   assign res_word.status       = last_byte ? status : dnsp_pkg::STATUS_OK;
   assign res_word.record_count = last_byte ? found_in : 8'd0;

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEADER;
         id_ff    <= '0;
         code_ff  <= '0;
         total_ff <= '0;
         seen_ff  <= '0;
         skip_ff  <= '0;
         rtype_ff <= '0;
         dlen_ff  <= '0;
         addr_ff  <= '0;
         found_ff <= '0;
      end else if (take) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         id_ff    <= id_in;
         code_ff  <= code_in;
         total_ff <= total_in;
         seen_ff  <= seen_in;
         skip_ff  <= skip_in;
         rtype_ff <= rtype_in;
         dlen_ff  <= dlen_in;
         addr_ff  <= addr_in;
         found_ff <= found_in;
      end
   end

endmodule

[rtl/core/dns_a_record_response_parser_core.sv]
`timescale 1ns / 1ps
// Top level of the DNS A-record response parser with its output register.
// The parser takes one message byte per word on the request channel and can accept a word
// in every clock cycle. Each byte is parsed in the cycle it is accepted, and a result word
// appears on the response channel in the next cycle from an output register: one word for each
// completed A-record address, one for the byte marked last (status and record count), or a
// single word carrying both. Bytes that produce no result produce no response word. The
// request side stalls only while a result waits in the output register and the response side
// is not ready. The user must write the expected transaction id over APB at address 0 only
// while no message is in flight; the block itself does not enforce this.
module dns_a_record_response_parser_core (
   input  logic                             clock,
   input  logic                             reset,
   dnsp_req_if.sink                         req_chan,
   dnsp_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dnsp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dnsp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dnsp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   logic                   take;
   logic [15:0]            expected_id;
   logic                   res_valid;
   dnsp_pkg::rsp_word_type res_word;
   logic                   out_valid_ff, out_valid_in;
   dnsp_pkg::rsp_word_type out_word_ff;

   dnsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .expected_id (expected_id)
   );

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   dnsp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .byte_value  (req_chan.byte_value),
      .last_byte   (req_chan.last_byte),
      .expected_id (expected_id),
      .res_valid   (res_valid),
      .res_word    (res_word)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (req_chan.ready) begin
         out_valid_in = take && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.record_valid = out_word_ff.record_valid;
   assign rsp_chan.address      = out_word_ff.address;
   assign rsp_chan.done_res     = out_word_ff.done_res;
   assign rsp_chan.status       = out_word_ff.status;
   assign rsp_chan.record_count = out_word_ff.record_count;

   // A waiting result that is not taken must hold off the next byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while a result is stalled");

   // Every result word carries an address, a message end, or both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.record_valid || rsp_chan.done_res))
      else $error("empty result word");

   // Status and count are reported only with the message end.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.done_res) |->
         (rsp_chan.status == dnsp_pkg::STATUS_OK && rsp_chan.record_count == 8'd0))
      else $error("status reported without message end");

   // An address is reported only with an A record.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.record_valid) |-> (rsp_chan.address == 32'd0))
      else $error("address reported without a record");

endmodule

[sim/dns_a_record_response_parser_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench that streams DNS responses through the parser.
module dns_a_record_response_parser_core_test;

   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          PHASE_BYTES    = 60;
   localparam int          HEADER_BYTES   = 12;
   localparam logic [15:0] FIXED_BYTES    = 16'd10;
   localparam logic [7:0]  PTR_BITS       = 8'hC0;
   localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;
   localparam logic [15:0] TYPE_A         = 16'd1;
   localparam logic [15:0] A_DATA_LEN     = 16'd4;

   typedef enum logic [3:0] {
      P_HEADER, P_QNAME, P_QLABEL, P_QTAIL, P_ANAME,
      P_ALABEL, P_APTR, P_AFIXED, P_ADATA, P_IDLE
   } dns_phase_type;

   typedef enum int {NAME_ROOT, NAME_LABELS, NAME_PTR, NAME_LABELS_PTR} name_form_type;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
      logic       drain_first;
   } msg_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dnsp_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dnsp_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dnsp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   dnsp_req_if req_chan();
   dnsp_rsp_if rsp_chan();

   dns_a_record_response_parser_core uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [15:0]   id_cfg;
   int            msg_pos;
   dns_phase_type phase;
   logic [15:0]   resp_id;
   logic [3:0]    rcode;
   logic [15:0]   an_total;
   logic [15:0]   an_seen;
   logic [15:0]   skip_left;
   logic [15:0]   rr_type;
   logic [15:0]   rr_len;
   logic [31:0]   addr_acc;
   logic [7:0]    a_found;

   msg_byte_type           tx_bytes[$];
   dnsp_pkg::rsp_word_type report_queue[$];
   logic [7:0]             msg_bytes[$];

   int phase_bytes;
   int gap_left;
   int stall_left;
   int mismatches = 0;
   int cycle_count = 0;
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   bit byte_in_flight = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic clear_message();
      msg_pos = 0;
      phase = P_HEADER;
      resp_id = '0;
      rcode = '0;
      an_total = '0;
      an_seen = '0;
      skip_left = '0;
      rr_type = '0;
      rr_len = '0;
      addr_acc = '0;
      a_found = '0;
   endtask

   task automatic enter_name_byte(input logic [7:0] b, input dns_phase_type end_phase,
                                  input dns_phase_type ptr_phase, input logic [15:0] end_skip,
                                  input logic [15:0] ptr_skip,
                                  input dns_phase_type label_phase);
      if (b == 8'h00) begin
         skip_left = end_skip;
         phase = end_phase;
      end else if ((b & PTR_BITS) == PTR_BITS) begin
         skip_left = ptr_skip;
         phase = ptr_phase;
      end else begin
         skip_left = {8'h00, b};
         phase = label_phase;
      end
   endtask

   task automatic close_record();
      an_seen = an_seen + 16'd1;
      phase = (an_seen < an_total) ? P_ANAME : P_IDLE;
   endtask

   task automatic track_dns_byte(input logic [7:0] b, input logic is_last);
      logic                   hit;
      int                     fixed_idx;
      dnsp_pkg::rsp_word_type word;
      hit = 1'b0;
      if (msg_pos < dnsp_pkg::MAX_MESSAGE) begin
         case (phase)
            P_HEADER: begin
               case (msg_pos)
                  0: resp_id = {b, 8'h00};
                  1: resp_id[7:0] = b;
                  3: rcode = b[3:0];
                  6: an_total = {b, 8'h00};
                  7: an_total[7:0] = b;
                  default: ;
               endcase
               if (msg_pos == HEADER_BYTES - 1) begin
                  phase = (resp_id == id_cfg && rcode == 4'd0) ? P_QNAME : P_IDLE;
               end
            end
            P_QNAME: enter_name_byte(b, P_QTAIL, P_QTAIL, 16'd4, 16'd5, P_QLABEL);
            P_QLABEL: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) phase = P_QNAME;
            end
            P_QTAIL: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) phase = (an_seen < an_total) ? P_ANAME : P_IDLE;
            end
            P_ANAME: enter_name_byte(b, P_AFIXED, P_APTR, FIXED_BYTES, 16'd1, P_ALABEL);
            P_ALABEL: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) phase = P_ANAME;
            end
            P_APTR: begin
               skip_left = FIXED_BYTES;
               phase = P_AFIXED;
            end
            P_AFIXED: begin
               fixed_idx = FIXED_BYTES - skip_left;
               case (fixed_idx)
                  0: rr_type = {b, 8'h00};
                  1: rr_type[7:0] = b;
                  8: rr_len = {b, 8'h00};
                  9: rr_len[7:0] = b;
                  default: ;
               endcase
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) begin
                  addr_acc = '0;
                  if (rr_len == 16'd0) begin
                     close_record();
                  end else begin
                     skip_left = rr_len;
                     phase = P_ADATA;
                  end
               end
            end
            P_ADATA: begin
               addr_acc = {addr_acc[23:0], b};
               skip_left = skip_left - 16'd1;
               if (skip_left == 16'd0) begin
                  hit = (rr_type == TYPE_A && rr_len == A_DATA_LEN);
                  if (hit && a_found != 8'hFF) a_found = a_found + 8'd1;
                  close_record();
               end
            end
            default: ;
         endcase
         msg_pos++;
      end
      if (hit || is_last) begin
         word = '0;
         word.record_valid = hit;
         word.address = hit ? addr_acc : 32'h0;
         word.done_res = is_last;
         if (is_last) begin
            if (msg_pos < HEADER_BYTES) word.status = dnsp_pkg::STATUS_SHORT;
            else if (resp_id != id_cfg) word.status = dnsp_pkg::STATUS_ID_ERR;
            else if (rcode == RCODE_NXDOMAIN) word.status = dnsp_pkg::STATUS_NAME_ERR;
            else if (rcode != 4'd0) word.status = dnsp_pkg::STATUS_SERVER;
            else word.status = dnsp_pkg::STATUS_OK;
            word.record_count = a_found;
            clear_message();
         end
         report_queue.push_back(word);
      end
   endtask

   function automatic int draw_wait(input bit enabled);
      if (!enabled || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   task automatic note_mismatch(input string what, input dnsp_pkg::rsp_word_type want,
                                input dnsp_pkg::rsp_word_type seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected rv=%0b addr=%h done=%0b st=%0d cnt=%0d",
                  $realtime, what, want.record_valid, want.address, want.done_res,
                  want.status, want.record_count);
         $display("   got rv=%0b addr=%h done=%0b st=%0d cnt=%0d",
                  seen.record_valid, seen.address, seen.done_res, seen.status,
                  seen.record_count);
      end
   endtask

   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_chan.valid <= 1'b0;
         byte_in_flight = 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_dns_byte(req_chan.byte_value, req_chan.last_byte);
            void'(tx_bytes.pop_front());
            byte_in_flight = 1'b0;
            gap_left = draw_wait(gaps_on);
         end
         if (!byte_in_flight) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (tx_bytes.size() != 0 &&
                         (!tx_bytes[0].drain_first || report_queue.size() == 0)) begin
               req_chan.byte_value <= tx_bytes[0].value;
               req_chan.last_byte <= tx_bytes[0].is_last;
               byte_in_flight = 1'b1;
            end
         end
         req_chan.valid <= byte_in_flight;
      end
   end

   always @(posedge clock) begin : result_monitor
      dnsp_pkg::rsp_word_type seen;
      dnsp_pkg::rsp_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.record_valid = rsp_chan.record_valid;
            seen.address = rsp_chan.address;
            seen.done_res = rsp_chan.done_res;
            seen.status = rsp_chan.status;
            seen.record_count = rsp_chan.record_count;
            if (report_queue.size() == 0) begin
               note_mismatch("unexpected result word", '0, seen);
            end else begin
               want = report_queue.pop_front();
               if (seen !== want) note_mismatch("result word mismatch", want, seen);
            end
            stall_left = draw_wait(stalls_on);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL dns_a_record_response_parser_core");
         $finish;
      end
   end

   task automatic add_header(input logic [15:0] id, input logic [3:0] code,
                             input logic [15:0] count);
      logic [3:0] flags;
      flags = 4'($urandom_range(0, 15));
      msg_bytes.push_back(id[15:8]);
      msg_bytes.push_back(id[7:0]);
      msg_bytes.push_back(8'($urandom_range(0, 255)));
      msg_bytes.push_back({flags, code});
      repeat (2) msg_bytes.push_back(8'($urandom_range(0, 255)));
      msg_bytes.push_back(count[15:8]);
      msg_bytes.push_back(count[7:0]);
      repeat (4) msg_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_labels();
      int count;
      int len;
      count = $urandom_range(1, 3);
      repeat (count) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(8'h40, 8'hBF)
                                              : $urandom_range(1, 9);
         msg_bytes.push_back(len[7:0]);
         repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_name(input name_form_type form);
      logic [5:0] offset_hi;
      offset_hi = 6'($urandom_range(0, 63));
      if (form == NAME_LABELS || form == NAME_LABELS_PTR) add_labels();
      if (form == NAME_PTR || form == NAME_LABELS_PTR) begin
         msg_bytes.push_back(PTR_BITS | {2'b00, offset_hi});
         msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         msg_bytes.push_back(8'h00);
      end
   endtask

   task automatic add_question(input name_form_type form);
      add_name(form);
      repeat (4) msg_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_answer(input name_form_type form, input logic [15:0] rr_t,
                             input logic [15:0] rr_l);
      add_name(form);
      msg_bytes.push_back(rr_t[15:8]);
      msg_bytes.push_back(rr_t[7:0]);
      repeat (6) msg_bytes.push_back(8'($urandom_range(0, 255)));
      msg_bytes.push_back(rr_l[15:8]);
      msg_bytes.push_back(rr_l[7:0]);
      repeat (rr_l) msg_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_random_answer();
      logic [15:0] rr_t;
      logic [15:0] rr_l;
      if ($urandom_range(0, 3) != 0) begin
         rr_t = TYPE_A;
         rr_l = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 8)) : A_DATA_LEN;
      end else begin
         rr_t = 16'($urandom_range(0, 65535));
         rr_l = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
      end
      add_answer(name_form_type'($urandom_range(0, 3)), rr_t, rr_l);
   endtask

   task automatic queue_message(input bit drain_first);
      msg_byte_type item;
      for (int i = 0; i < msg_bytes.size(); i++) begin
         item.value = msg_bytes[i];
         item.is_last = (i == msg_bytes.size() - 1);
         item.drain_first = drain_first && (i == 0);
         tx_bytes.push_back(item);
      end
      phase_bytes += msg_bytes.size();
      msg_bytes.delete();
   endtask

   task automatic queue_random_message(input bit drain_first);
      int          kind;
      int          records;
      int          keep;
      logic [15:0] id;
      logic [15:0] flip;
      logic [15:0] count;
      logic [3:0]  code;
      kind = $urandom_range(0, 99);
      records = $urandom_range(0, 4);
      flip = 16'($urandom_range(1, 65535));
      if (kind < 86) begin
         id = (kind >= 70 && kind < 78) ? (id_cfg ^ flip) : id_cfg;
         code = 4'd0;
         if (kind >= 78) begin
            code = $urandom_range(0, 1) ? RCODE_NXDOMAIN : 4'($urandom_range(1, 15));
         end
         case ($urandom_range(0, 9))
            0: count = 16'(records + $urandom_range(1, 3));
            1: count = (records > 0) ? 16'(records - 1) : 16'd0;
            2: count = 16'hFFFF;
            default: count = 16'(records);
         endcase
         add_header(id, code, count);
         add_question(name_form_type'($urandom_range(0, 3)));
         repeat (records) add_random_answer();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
         end
      end else if (kind < 92) begin
         repeat ($urandom_range(1, HEADER_BYTES - 1)) begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         add_header(id_cfg, 4'd0, 16'($urandom_range(0, 65535)));
         repeat ($urandom_range(1, 60)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      queue_message(drain_first);
   endtask

   task automatic await_idle();
      while (tx_bytes.size() != 0 || byte_in_flight || report_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_expected_id(input logic [15:0] value);
      logic [dnsp_pkg::CSR_ADDR_W-1:0] addr;
      addr = dnsp_pkg::CSR_ADDR_W'(4 * dnsp_pkg::REG_EXPECTED_ID);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      id_cfg = value;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      id_cfg = dnsp_pkg::EXPECTED_ID_RESET;
      clear_message();
      phase_bytes = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      msg_bytes.push_back(8'h00);
      queue_message(1'b0);
      repeat (HEADER_BYTES - 1) msg_bytes.push_back(8'hFF);
      queue_message(1'b0);
      add_header(dnsp_pkg::EXPECTED_ID_RESET, 4'd0, 16'd0);
      queue_message(1'b0);
      add_header(dnsp_pkg::EXPECTED_ID_RESET ^ 16'h0001, 4'd0, 16'd0);
      queue_message(1'b0);
      add_header(dnsp_pkg::EXPECTED_ID_RESET, RCODE_NXDOMAIN, 16'd0);
      queue_message(1'b0);
      add_header(dnsp_pkg::EXPECTED_ID_RESET, 4'hF, 16'd3);
      queue_message(1'b0);

      // A name, a five-byte A data, a zero length and a cut-off address in one response.
      add_header(dnsp_pkg::EXPECTED_ID_RESET, 4'd0, 16'd5);
      add_question(NAME_LABELS_PTR);
      add_answer(NAME_PTR, TYPE_A, A_DATA_LEN);
      add_answer(NAME_LABELS_PTR, TYPE_A, 16'd5);
      add_answer(NAME_ROOT, 16'd5, 16'd0);
      add_answer(NAME_LABELS, TYPE_A, A_DATA_LEN);
      add_answer(NAME_PTR, TYPE_A, A_DATA_LEN);
      void'(msg_bytes.pop_back());
      void'(msg_bytes.pop_back());
      queue_message(1'b1);

      // The final byte also completes an address, so one word carries both.
      add_header(dnsp_pkg::EXPECTED_ID_RESET, 4'd0, 16'd1);
      add_question(NAME_ROOT);
      add_answer(NAME_PTR, TYPE_A, A_DATA_LEN);
      queue_message(1'b0);

      for (int p = 0; p < 4; p++) begin
         await_idle();
         case (p)
            0: write_expected_id(16'h0000);
            1: write_expected_id(16'hFFFF);
            default: write_expected_id(16'($urandom_range(0, 65535)));
         endcase
         gaps_on = (p != 2);
         stalls_on = (p != 3);
         @(negedge clock);
         phase_bytes = 0;
         if (p == 1) begin
            add_header(id_cfg, 4'd0, 16'hFFFF);
            add_question(NAME_PTR);
            while (msg_bytes.size() < dnsp_pkg::MAX_MESSAGE + 30) add_random_answer();
            queue_message(1'b0);
         end
         queue_random_message(1'b1);
         while (phase_bytes < PHASE_BYTES) queue_random_message(1'b0);
      end

      while (tx_bytes.size() != 0 || byte_in_flight || report_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (30) @(negedge clock);
      if (mismatches == 0 && report_queue.size() == 0) begin
         $display("PASS dns_a_record_response_parser_core");
      end else begin
         $display("FAIL dns_a_record_response_parser_core");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/dnsp_pkg.sv
rtl/core/dnsp_req_if.sv
rtl/core/dnsp_rsp_if.sv
rtl/core/dnsp_csr.sv
rtl/core/dnsp_parse.sv
rtl/core/dns_a_record_response_parser_core.sv
sim/dns_a_record_response_parser_core_test.sv
